@@ src/ioro_pkg.sv @@
`default_nettype none

package ioro_pkg;

  // Field widths of the item and result words.
  localparam int ID_W  = 16;
  localparam int VAL_W = 32;
  localparam int TOT_W = 17;

  // Sequence length used after reset and for out-of-range register values.
  localparam logic [TOT_W-1:0] FULL_TOTAL = 17'h10000;

  // Default depth of the holding window.
  localparam int WINDOW_DEF = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;     // an input word is accepted this cycle
    logic drain_emit;  // the next held entry moves to the output register
  } ioro_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // the output register can be loaded this cycle
    logic hit;         // the offered word is good and carries the expected id
    logic more;        // the entry after the expected id is held and in range
  } ioro_status_t;

endpackage

`default_nettype wire

@@ src/ioro_item_if.sv @@
`default_nettype none

interface ioro_item_if;
  import ioro_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ID_W-1:0]         item_id;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, output item_id, output item_value, input ready);
  modport sink (input valid, input item_id, input item_value, output ready);

endinterface

`default_nettype wire

@@ src/ioro_result_if.sv @@
`default_nettype none

interface ioro_result_if;
  import ioro_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ID_W-1:0]         out_id;
  logic signed [VAL_W-1:0] out_value;
  logic                    run_last;
  logic                    sequence_done;
  logic                    bad_item;

  modport source (
    output valid, output out_id, output out_value, output run_last,
    output sequence_done, output bad_item, input ready
  );
  modport sink (
    input valid, input out_id, input out_value, input run_last,
    input sequence_done, input bad_item, output ready
  );

endinterface

`default_nettype wire

@@ src/in_order_result_reorder_core.sv @@
// Reorder buffer: words tagged with a sequence id arrive in any order and leave strictly
// in id order. A word with the expected id is passed on at once, followed by every held
// word that is now next in line; a word further ahead, within WINDOW ids of the expected
// one, is parked in a slot of the holding memory chosen by its id modulo WINDOW. A word
// that is behind, past the sequence length, outside the window or a duplicate of a held
// slot is answered with a single result flagged bad_item and is dropped. A word that
// releases held entries is followed by them, one result per cycle while results are
// accepted, paced by the output register and the single read port of the holding memory,
// whose next slot is read ahead as the expected id advances. The input is not ready
// while a run drains or an unaccepted result blocks the output register. The sequence
// length register (cfg_wdata, written with cfg_we by the user only while idle; the block
// does not enforce this) resets to 65536; zero or values above 65536 act as 65536.
`default_nettype none

module in_order_result_reorder_core #(
  parameter int WINDOW = ioro_pkg::WINDOW_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [ioro_pkg::TOT_W-1:0] cfg_wdata,
  ioro_item_if.sink                       item_in,
  ioro_result_if.source                   result_out
);
  import ioro_pkg::*;

  ioro_cmd_t    cmd;
  ioro_status_t status;

  // Sequencing of accepts and drained words.
  ioro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Classification, holding memory and output register.
  ioro_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_id        (item_in.item_id),
    .in_value     (item_in.item_value),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (result_out.ready),
    .out_valid    (result_out.valid),
    .out_id       (result_out.out_id),
    .out_value    (result_out.out_value),
    .out_run_last (result_out.run_last),
    .out_done     (result_out.sequence_done),
    .out_bad      (result_out.bad_item)
  );

endmodule

`default_nettype wire

@@ src/ioro_ram.sv @@
`default_nettype none

module ioro_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; rdata holds when re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/ioro_ctrl.sv @@
`default_nettype none

module ioro_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire ioro_pkg::ioro_status_t status,
  output      ioro_pkg::ioro_cmd_t   cmd
);
  import ioro_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Handshake and commands follow directly from the state and the datapath status.
  always_comb begin
    in_ready       = (state == S_IDLE) && status.out_free;
    cmd.take_in    = in_ready && in_valid;
    cmd.drain_emit = (state == S_DRAIN) && status.out_free;
  end

  // Enter the drain state when an in-order word releases held entries; leave it after the last.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.take_in && status.hit && status.more) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cmd.drain_emit && !status.more) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ src/ioro_datapath.sv @@
`default_nettype none

module ioro_datapath #(
  parameter int WINDOW = ioro_pkg::WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ioro_pkg::TOT_W-1:0]        cfg_wdata,
  input  wire logic [ioro_pkg::ID_W-1:0]         in_id,
  input  wire logic signed [ioro_pkg::VAL_W-1:0] in_value,
  input  wire ioro_pkg::ioro_cmd_t               cmd,
  output      ioro_pkg::ioro_status_t            status,
  input  wire logic                              out_ready,
  output      logic                              out_valid,
  output      logic [ioro_pkg::ID_W-1:0]         out_id,
  output      logic signed [ioro_pkg::VAL_W-1:0] out_value,
  output      logic                              out_run_last,
  output      logic                              out_done,
  output      logic                              out_bad
);
  import ioro_pkg::*;

  localparam int SW = $clog2(WINDOW);
  localparam int VD = 1 << SW;

  localparam logic [SW:0]      WIN_S  = (SW + 1)'(WINDOW);
  localparam logic [SW-1:0]    LAST_S = SW'(WINDOW - 1);
  localparam logic [TOT_W-1:0] WIN_T  = TOT_W'(WINDOW);

  // Architectural state.
  logic [TOT_W-1:0] total_items;
  logic [TOT_W-1:0] next_expected;
  logic [SW-1:0]    ne_slot;
  logic [VD-1:0]    held_valid;
  logic [TOT_W-1:0] received_count;

  // Classification of the offered word.
  logic [TOT_W-1:0] tot_eff;
  logic [TOT_W-1:0] id_ext;
  logic [TOT_W-1:0] diff;
  logic [SW:0]      slot_sum;
  logic [SW:0]      slot_wrap;
  logic [SW-1:0]    slot;
  logic [SW-1:0]    ne_slot_inc;
  logic [TOT_W-1:0] ne_plus;
  logic             bad;
  logic             is_done;

  // Holding memory ports.
  logic             ram_we;
  logic             ram_re;
  logic [VAL_W-1:0] ram_rdata;

  always_comb begin
    if (total_items == '0 || total_items > FULL_TOTAL) begin
      tot_eff = FULL_TOTAL;
    end else begin
      tot_eff = total_items;
    end
    id_ext = {1'b0, in_id};
    diff   = id_ext - next_expected;

    // Slot of the offered id, valid whenever the id lies inside the window.
    slot_sum  = {1'b0, ne_slot} + {1'b0, diff[SW-1:0]};
    slot_wrap = (slot_sum >= WIN_S) ? (slot_sum - WIN_S) : slot_sum;
    slot      = slot_wrap[SW-1:0];

    ne_slot_inc = (ne_slot == LAST_S) ? '0 : (ne_slot + 1'b1);
    ne_plus     = next_expected + 1'b1;

    bad = (id_ext < next_expected) || (id_ext >= tot_eff) || (diff >= WIN_T)
          || held_valid[slot];
    is_done = (next_expected == (tot_eff - 1'b1));

    status.out_free = !out_valid || out_ready;
    status.hit      = !bad && (diff == '0);
    status.more     = (ne_plus < tot_eff) && held_valid[ne_slot_inc];
  end

  // Park out-of-order words; fetch the next slot whenever the expected id advances.
  assign ram_we = cmd.take_in && !bad && (diff != '0);
  assign ram_re = (cmd.take_in && status.hit) || cmd.drain_emit;

  ioro_ram #(
    .WIDTH (VAL_W),
    .DEPTH (WINDOW)
  ) u_held (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (VAL_W'($unsigned(in_value))),
    .re    (ram_re),
    .raddr (ne_slot_inc),
    .rdata (ram_rdata)
  );

  // Register, expected id, valid marks and received count.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_items    <= FULL_TOTAL;
      next_expected  <= '0;
      ne_slot        <= '0;
      held_valid     <= '0;
      received_count <= '0;
    end else begin
      if (cfg_we) begin
        total_items <= cfg_wdata;
      end
      if (cmd.take_in && !bad && (received_count < tot_eff)) begin
        received_count <= received_count + 1'b1;
      end
      if (ram_we) begin
        held_valid[slot] <= 1'b1;
      end
      if (cmd.drain_emit) begin
        held_valid[ne_slot] <= 1'b0;
      end
      if (ram_re) begin
        next_expected <= ne_plus;
        ne_slot       <= ne_slot_inc;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.take_in && (bad || status.hit)) || cmd.drain_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.take_in && bad) begin
      out_id       <= in_id;
      out_value    <= in_value;
      out_run_last <= 1'b1;
      out_done     <= 1'b0;
      out_bad      <= 1'b1;
    end else if (cmd.take_in && status.hit) begin
      out_id       <= in_id;
      out_value    <= in_value;
      out_run_last <= !status.more;
      out_done     <= is_done;
      out_bad      <= 1'b0;
    end else if (cmd.drain_emit) begin
      out_id       <= next_expected[ID_W-1:0];
      out_value    <= $signed(ram_rdata);
      out_run_last <= !status.more;
      out_done     <= is_done;
      out_bad      <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ src/ioro_checker.sv @@
`default_nettype none

module ioro_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [ioro_pkg::ID_W-1:0]         out_id,
  input wire logic signed [ioro_pkg::VAL_W-1:0] out_value,
  input wire logic                              run_last,
  input wire logic                              sequence_done,
  input wire logic                              bad_item
);

  // A stalled result word stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_value))
    else $error("result word changed while stalled");

  // A rejected word ends its own run and never closes the sequence.
  a_bad_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_item |-> run_last && !sequence_done)
    else $error("bad result with wrong run flags");

  // No new word is taken while a run of released entries is still draining.
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> !in_ready)
    else $error("input ready in the middle of a run");

  // Within a run the next good result carries the following id.
  a_run_ids: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> !out_valid || (out_id == $past(out_id) + 1'b1))
    else $error("run ids not consecutive");

endmodule

bind in_order_result_reorder_core ioro_checker u_ioro_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (item_in.ready),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .out_id        (result_out.out_id),
  .out_value     (result_out.out_value),
  .run_last      (result_out.run_last),
  .sequence_done (result_out.sequence_done),
  .bad_item      (result_out.bad_item)
);

`default_nettype wire

@@ tb/sv/tb_in_order_result_reorder_core.sv @@
`timescale 1ns / 100ps

module tb_in_order_result_reorder_core;
  import ioro_pkg::*;

  localparam int HOLD_WINDOW  = WINDOW_DEF;
  localparam int WORD_TARGET  = 470;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT  = 3000;
  localparam int IDLE_PERCENT = 26;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [VAL_W-1:0] value;
    logic                    run_last;
    logic                    seq_done;
    logic                    bad;
  } reorder_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [TOT_W-1:0] cfg_wdata;

  ioro_item_if   item_bus ();
  ioro_result_if result_bus ();

  in_order_result_reorder_core u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_in    (item_bus),
    .result_out (result_bus)
  );

  // Shadow copy of the reorder state and the sequence length register.
  logic [TOT_W-1:0] seq_length;
  logic [TOT_W-1:0] exp_next;
  logic [TOT_W-1:0] taken_count;
  logic [VAL_W-1:0] park_value [HOLD_WINDOW];
  logic             park_valid [HOLD_WINDOW];

  reorder_result_t pending_results [$];
  reorder_result_t got_word;
  reorder_result_t want_word;

  int  error_count;
  int  words_sent;
  int  hold_cycles;
  int  quiet_cycles;
  bit  steady;

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Sequence length as the block applies it: zero or too large means full length.
  function automatic int unsigned active_length();
    if (seq_length == '0 || seq_length > FULL_TOTAL) return FULL_TOTAL;
    return seq_length;
  endfunction

  // Work out the result words caused by one accepted item and queue them.
  function automatic void predict_release(input logic [ID_W-1:0] id,
                                          input logic [VAL_W-1:0] value);
    int unsigned     total;
    int unsigned     idn;
    int unsigned     nx;
    int              slot;
    int              i;
    reorder_result_t r;
    reorder_result_t run [$];
    total = active_length();
    idn   = id;
    nx    = exp_next;
    slot  = idn % HOLD_WINDOW;
    // Behind, past the sequence, outside the window or a duplicate slot.
    if (idn < nx || idn >= total || idn - nx >= HOLD_WINDOW || park_valid[slot]) begin
      r.id       = id;
      r.value    = value;
      r.run_last = 1'b1;
      r.seq_done = 1'b0;
      r.bad      = 1'b1;
      pending_results.push_back(r);
      return;
    end
    if (taken_count < total) taken_count = taken_count + 1'b1;
    // An item ahead of the expected id is parked.
    if (idn != nx) begin
      park_value[slot] = value;
      park_valid[slot] = 1'b1;
      return;
    end
    r.id       = id;
    r.value    = value;
    r.run_last = 1'b0;
    r.seq_done = (idn == total - 1);
    r.bad      = 1'b0;
    run.push_back(r);
    nx++;
    // Drain every parked entry that is now next in line.
    while (nx < total && run.size() < HOLD_WINDOW) begin
      slot = nx % HOLD_WINDOW;
      if (!park_valid[slot]) break;
      r.id       = ID_W'(nx);
      r.value    = park_value[slot];
      r.seq_done = (nx == total - 1);
      park_valid[slot] = 1'b0;
      run.push_back(r);
      nx++;
    end
    exp_next = TOT_W'(nx);
    for (i = 0; i < run.size(); i++) begin
      r = run[i];
      r.run_last = (i == run.size() - 1);
      pending_results.push_back(r);
    end
  endfunction

  // Offer one word after a random gap and wait until it is taken.
  task automatic send_word(input logic [ID_W-1:0] id, input logic [VAL_W-1:0] value);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid      <= 1'b1;
    item_bus.item_id    <= id;
    item_bus.item_value <= value;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    words_sent++;
    predict_release(id, value);
  endtask

  // Stop offering and wait until every expected word has come out.
  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [TOT_W-1:0] length);
    cfg_we    <= 1'b1;
    cfg_wdata <= length;
    @(posedge clk);
    cfg_we     <= 1'b0;
    seq_length = length;
  endtask

  // Pick an id that the block has to reject, or that lands somewhere odd.
  function automatic logic [ID_W-1:0] noise_id(input int unsigned base,
                                                input logic [ID_W-1:0] dup);
    case ($urandom_range(3))
      0: return (base > 0) ? ID_W'($urandom_range(base - 1)) : ID_W'(base + HOLD_WINDOW);
      1: return ID_W'(base + HOLD_WINDOW + $urandom_range(500));
      2: return ID_W'($urandom);
      default: return dup;
    endcase
  endfunction

  // Send a shuffled run of consecutive ids from the expected one, with some noise.
  task automatic send_random_block(input int max_len);
    int unsigned     base;
    int unsigned     total;
    int unsigned     len;
    int unsigned     pick;
    int              j;
    logic [ID_W-1:0] ids [$];
    logic [ID_W-1:0] tmp;
    base  = exp_next;
    total = active_length();
    len   = $urandom_range(max_len, 1);
    if (total <= base) len = $urandom_range(8, 1);
    else if (len > total - base && $urandom_range(9) != 0) len = total - base;
    for (j = 0; j < len; j++) ids.push_back(ID_W'(base + j));
    for (j = len - 1; j > 0; j--) begin
      pick     = $urandom_range(j);
      tmp      = ids[j];
      ids[j]   = ids[pick];
      ids[pick] = tmp;
    end
    for (j = 0; j < len; j++) begin
      if ($urandom_range(99) < 15)
        send_word(noise_id(base, ids[$urandom_range(len - 1)]), $urandom);
      send_word(ids[j], $urandom);
    end
  endtask

  // A sequence of one item, the shortest length.
  task automatic test_shortest_sequence();
    write_length(TOT_W'(1));
    send_word(16'd1, 32'h0000_1234);
    send_word(16'd0, 32'h7FFF_FFFF);
    wait_drained();
  endtask

  // Parking, duplicate and out-of-window rejections, and a released run.
  task automatic test_parking_and_rejects();
    write_length(FULL_TOTAL);
    send_word(16'd2, 32'h8000_0000);
    send_word(16'd3, 32'hFFFF_FFFF);
    send_word(16'd2, 32'h0000_0055);
    send_word(16'd0, 32'h0000_00AA);
    send_word(16'd65, 32'h1357_9BDF);
    send_word(16'd64, 32'h2468_ACE0);
    send_word(16'hFFFF, 32'hFFFF_0000);
    send_word(16'd1, 32'h0000_0000);
    wait_drained();
  endtask

  // A short length ends the sequence; later items are rejected.
  task automatic test_sequence_end();
    write_length(TOT_W'(6));
    send_word(16'd5, 32'h5555_5555);
    send_word(16'd4, 32'hAAAA_AAAA);
    send_word(16'd6, 32'h0F0F_0F0F);
    send_word(16'd3, 32'hF0F0_F0F0);
    wait_drained();
  endtask

  // Lowering the length stops a drain; raising it again releases the rest.
  task automatic test_length_change();
    write_length('0);
    send_word(16'd6, 32'h0000_0006);
    send_word(16'd8, 32'h0000_0008);
    send_word(16'd10, 32'h0000_000A);
    wait_drained();
    write_length(TOT_W'(9));
    send_word(16'd7, 32'h0000_0007);
    wait_drained();
    write_length(17'h1FFFF);
    send_word(16'd9, 32'h0000_0009);
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering, then a full-window run.
  task automatic test_backpressure();
    int unsigned base;
    int          j;
    write_length(FULL_TOTAL);
    base        = exp_next;
    steady      = 1'b1;
    hold_cycles = 250;
    send_word(16'd0, 32'hDEAD_BEEF);
    send_word(ID_W'(base + HOLD_WINDOW), 32'hBEEF_DEAD);
    for (j = 1; j < HOLD_WINDOW; j++) send_word(ID_W'(base + j), $urandom);
    send_word(ID_W'(base), $urandom);
    steady = 1'b0;
    wait_drained();
  endtask

  // Both sides run without any idle cycle.
  task automatic test_no_idle();
    steady = 1'b1;
    repeat (4) send_random_block(24);
    wait_drained();
    steady = 1'b0;
  endtask

  // Random runs under a range of sequence lengths.
  task automatic test_random_runs();
    logic [TOT_W-1:0] length;
    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(6))
        0: length = '0;
        1: length = FULL_TOTAL;
        2: length = 17'h1FFFF;
        3: length = TOT_W'($urandom_range(17'h1FFFF, 17'h10001));
        default: length = TOT_W'(exp_next + $urandom_range(150, 1));
      endcase
      write_length(length);
      repeat ($urandom_range(5, 2)) begin
        if (words_sent < WORD_TARGET) send_random_block(HOLD_WINDOW);
      end
      wait_drained();
    end
  endtask

  // Result side: check each accepted word, then choose the next ready.
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got_word.id       = result_bus.out_id;
        got_word.value    = result_bus.out_value;
        got_word.run_last = result_bus.run_last;
        got_word.seq_done = result_bus.sequence_done;
        got_word.bad      = result_bus.bad_item;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word id %0d", got_word.id));
        end else begin
          want_word = pending_results.pop_front();
          if (got_word !== want_word)
            report_mismatch($sformatf(
              "id %0d/%0d value %h/%h last %b/%b done %b/%b bad %b/%b (got/exp)",
              got_word.id, want_word.id, got_word.value, want_word.value,
              got_word.run_last, want_word.run_last, got_word.seq_done,
              want_word.seq_done, got_word.bad, want_word.bad));
        end
      end
      if (hold_cycles > 0) begin
        result_bus.ready <= 1'b0;
        hold_cycles--;
      end else begin
        result_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** in_order_result_reorder_core: FAILED **");
      $finish;
    end
  end

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    item_bus.valid      <= 1'b0;
    item_bus.item_id    <= '0;
    item_bus.item_value <= '0;
    seq_length  = FULL_TOTAL;
    exp_next    = '0;
    taken_count = '0;
    error_count = 0;
    words_sent  = 0;
    hold_cycles = 0;
    steady      = 1'b0;
    foreach (park_valid[i]) begin
      park_valid[i] = 1'b0;
      park_value[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_shortest_sequence();
    test_parking_and_rejects();
    test_sequence_end();
    test_length_change();
    test_backpressure();
    test_no_idle();
    test_random_runs();

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("** in_order_result_reorder_core: PASSED **");
    end else begin
      $display("** in_order_result_reorder_core: FAILED **");
    end
    $finish;
  end

endmodule
